/* design/rsd_pkg.sv */
// rsd_pkg: shared types and constants of the rgbe scanline run-length decoder
// no dependencies; imported by every module of the decoder
`default_nettype none

package rsd_pkg;

    localparam int RSD_MAX_WIDTH   = 32767;
    localparam int RSD_QUEUE_DEPTH = 4;
    localparam int RSD_QPTR_W      = $clog2(RSD_QUEUE_DEPTH);

    // configuration register indexes
    localparam logic [1:0] REG_ROW_WIDTH = 2'd0;
    localparam logic [1:0] REG_ROW_TOTAL = 2'd1;

    localparam logic [1:0] CH_EXPONENT = 2'd3;
    localparam logic [1:0] HEADER_LAST = 2'd3;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_COUNT,
        PH_LITERAL,
        PH_RUN
    } rsd_phase_t;

    typedef enum logic {
        CMD_LIT,
        CMD_RUN
    } rsd_cmd_kind_t;

    // one unit of work handed from the front end to the back end
    typedef struct packed {
        rsd_cmd_kind_t kind;
        logic [7:0]    value;
        logic [6:0]    count;
        logic          last;
        logic          row_end;
        logic          image_end;
        logic          done;
        logic [1:0]    channel;
    } rsd_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } rsd_q_status_t;

endpackage

`default_nettype wire

/* design/rgbe_byte_if.sv */
// rgbe_byte_if: valid/ready channel carrying one raw body byte per transaction
// no dependencies
`default_nettype none

interface rgbe_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

`default_nettype wire

/* design/rgbe_result_if.sv */
// rgbe_result_if: valid/ready channel carrying one decoded result per transaction
// no dependencies
`default_nettype none

interface rgbe_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  channel;
    logic [14:0] column;
    logic [7:0]  first_value;
    logic [7:0]  second_value;
    logic        pair_valid;
    logic        in_range;
    logic        last_of_packet;
    logic        row_end;
    logic        image_end;

    modport source (
        output valid, output channel, output column, output first_value,
        output second_value, output pair_valid, output in_range,
        output last_of_packet, output row_end, output image_end,
        input ready
    );
    modport sink (
        input valid, input channel, input column, input first_value,
        input second_value, input pair_valid, input in_range,
        input last_of_packet, input row_end, input image_end,
        output ready
    );
endinterface

`default_nettype wire

/* design/rgbe_cfg_if.sv */
// rgbe_cfg_if: configuration write channel, register index plus write data
// no dependencies
`default_nettype none

interface rgbe_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  reg_index;
    logic [14:0] wdata;

    modport source (output valid, output reg_index, output wdata, input ready);
    modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

`default_nettype wire

/* design/rsd_queue.sv */
// rsd_queue: short command queue between front end and back end
// depends on rsd_pkg
`default_nettype none

module rsd_queue
    import rsd_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire rsd_cmd_t      push_data,
    input  wire logic          pop,
    output rsd_cmd_t           head,
    output rsd_q_status_t      status
);

    localparam int CNT_W = $clog2(RSD_QUEUE_DEPTH + 1);

    rsd_cmd_t                 mem [RSD_QUEUE_DEPTH];
    logic [RSD_QPTR_W-1:0]    wr_ptr_reg;
    logic [RSD_QPTR_W-1:0]    wr_ptr_next;
    logic [RSD_QPTR_W-1:0]    rd_ptr_reg;
    logic [RSD_QPTR_W-1:0]    rd_ptr_next;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic                     do_push;
    logic                     do_pop;

    always_comb
    begin
        status.full  = (count_reg == CNT_W'(RSD_QUEUE_DEPTH));
        status.empty = (count_reg == '0);
        do_push      = push && !status.full;
        do_pop       = pop && !status.empty;
        wr_ptr_next  = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next  = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next   = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
        head = mem[rd_ptr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

/* design/rsd_front.sv */
// rsd_front: takes body bytes, tracks header, packets, planes and rows,
// and queues literal and run commands; depends on rsd_pkg, rgbe_byte_if
`default_nettype none

module rsd_front
    import rsd_pkg::*;
#(
    parameter int MAX_WIDTH = RSD_MAX_WIDTH
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    rgbe_byte_if.sink                              pixel_bytes,
    input  wire logic [$clog2(MAX_WIDTH+256)-1:0]  eff_width,
    input  wire logic [14:0]                       eff_total,
    input  wire rsd_q_status_t                     q_status,
    output logic                                   push,
    output rsd_cmd_t                               push_data
);

    localparam int COL_W = $clog2(MAX_WIDTH + 256);

    rsd_phase_t         phase_reg;
    rsd_phase_t         phase_next;
    logic [1:0]         header_count_reg;
    logic [1:0]         header_count_next;
    logic [6:0]         literal_left_reg;
    logic [6:0]         literal_left_next;
    logic [6:0]         run_length_reg;
    logic [6:0]         run_length_next;
    logic [1:0]         plane_reg;
    logic [1:0]         plane_next;
    logic [COL_W-1:0]   col_reg;
    logic [COL_W-1:0]   col_next;
    logic [14:0]        row_reg;
    logic [14:0]        row_next;

    logic               accept;
    logic               do_end;
    logic [6:0]         add;
    logic [COL_W-1:0]   col_sum;
    logic [15:0]        row_p1;
    logic [7:0]         b;

    assign pixel_bytes.ready = !q_status.full;
    assign accept = pixel_bytes.valid && pixel_bytes.ready;
    assign b      = pixel_bytes.in_byte;

    always_comb
    begin
        phase_next        = phase_reg;
        header_count_next = header_count_reg;
        literal_left_next = literal_left_reg;
        run_length_next   = run_length_reg;
        plane_next        = plane_reg;
        col_next          = col_reg;
        row_next          = row_reg;
        do_end            = 1'b0;
        add               = '0;
        push              = 1'b0;
        push_data.kind      = CMD_RUN;
        push_data.value     = b;
        push_data.count     = '0;
        push_data.last      = 1'b1;
        push_data.row_end   = 1'b0;
        push_data.image_end = 1'b0;
        push_data.done      = 1'b0;
        push_data.channel   = plane_reg;

        if (accept)
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    header_count_next = header_count_reg + 1'b1;
                    if (header_count_reg == HEADER_LAST)
                    begin
                        phase_next = PH_COUNT;
                        plane_next = '0;
                        col_next   = '0;
                    end
                end
                PH_COUNT:
                begin
                    if (!b[7])
                    begin
                        literal_left_next = b[6:0];
                        if (b[6:0] == '0)
                        begin
                            // empty literal packet: a zero-length run in the back end
                            push   = 1'b1;
                            do_end = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_LITERAL;
                        end
                    end
                    else
                    begin
                        run_length_next = b[6:0];
                        phase_next      = PH_RUN;
                    end
                end
                PH_LITERAL:
                begin
                    literal_left_next = literal_left_reg - 1'b1;
                    add               = 7'd1;
                    push              = 1'b1;
                    push_data.kind    = CMD_LIT;
                    push_data.last    = (literal_left_next == '0);
                    do_end            = (literal_left_next == '0);
                end
                PH_RUN:
                begin
                    run_length_next = '0;
                    add             = run_length_reg;
                    push            = 1'b1;
                    push_data.count = run_length_reg;
                    do_end          = 1'b1;
                end
            endcase
        end

        col_sum = col_reg + COL_W'(add);
        if (phase_reg == PH_LITERAL || phase_reg == PH_RUN)
        begin
            col_next = accept ? col_sum : col_reg;
        end
        row_p1 = {1'b0, row_reg} + 16'd1;

        if (do_end)
        begin
            phase_next = PH_COUNT;
            if (col_sum >= eff_width)
            begin
                push_data.done = 1'b1;
                col_next       = '0;
                if (plane_reg != CH_EXPONENT)
                begin
                    plane_next = plane_reg + 1'b1;
                end
                else
                begin
                    plane_next        = '0;
                    phase_next        = PH_HEADER;
                    header_count_next = '0;
                    push_data.row_end = 1'b1;
                    if (row_p1 >= {1'b0, eff_total})
                    begin
                        row_next            = '0;
                        push_data.image_end = 1'b1;
                    end
                    else
                    begin
                        row_next = row_p1[14:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_HEADER;
            header_count_reg <= '0;
            literal_left_reg <= '0;
            run_length_reg   <= '0;
            plane_reg        <= '0;
            col_reg          <= '0;
            row_reg          <= '0;
        end
        else
        begin
            phase_reg        <= phase_next;
            header_count_reg <= header_count_next;
            literal_left_reg <= literal_left_next;
            run_length_reg   <= run_length_next;
            plane_reg        <= plane_next;
            col_reg          <= col_next;
            row_reg          <= row_next;
        end
    end

endmodule

`default_nettype wire

/* design/rsd_back.sv */
// rsd_back: pairs literal bytes, expands runs into byte pairs and drives the
// registered result channel; depends on rsd_pkg, rgbe_result_if
`default_nettype none

module rsd_back
    import rsd_pkg::*;
#(
    parameter int MAX_WIDTH = RSD_MAX_WIDTH
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic [$clog2(MAX_WIDTH+256)-1:0]  eff_width,
    input  wire rsd_cmd_t                          head,
    input  wire rsd_q_status_t                     q_status,
    output logic                                   pop,
    rgbe_result_if.source                          results
);

    localparam int COL_W = $clog2(MAX_WIDTH + 256);

    logic [COL_W-1:0]   col_reg;
    logic [COL_W-1:0]   col_next;
    logic               pend_valid_reg;
    logic               pend_valid_next;
    logic [7:0]         pend_byte_reg;
    logic [7:0]         pend_byte_next;
    logic               run_active_reg;
    logic               run_active_next;
    logic [6:0]         run_left_reg;
    logic [6:0]         run_left_next;
    logic               out_valid_reg;
    logic               out_valid_next;

    logic [1:0]         out_channel_reg;
    logic [14:0]        out_column_reg;
    logic [7:0]         out_first_reg;
    logic [7:0]         out_second_reg;
    logic               out_pair_reg;
    logic               out_in_range_reg;
    logic               out_last_reg;
    logic               out_row_end_reg;
    logic               out_image_end_reg;

    logic               can_emit;
    logic               at_edge;
    logic               emit;
    logic               two;
    logic               final_out;
    logic               finish;
    logic [7:0]         first_byte;
    logic [6:0]         left_cur;
    logic [6:0]         left_new;

    always_comb
    begin
        col_next        = col_reg;
        pend_valid_next = pend_valid_reg;
        pend_byte_next  = pend_byte_reg;
        run_active_next = run_active_reg;
        run_left_next   = run_left_reg;
        emit            = 1'b0;
        two             = 1'b0;
        final_out       = 1'b0;
        finish          = 1'b0;
        first_byte      = head.value;
        left_new        = '0;
        can_emit        = !out_valid_reg || results.ready;
        // last byte inside the row width goes out alone
        at_edge  = ({1'b0, col_reg} + (COL_W+1)'(1)) == {1'b0, eff_width};
        left_cur = run_active_reg ? run_left_reg : head.count;

        if (!q_status.empty)
        begin
            unique case (head.kind)
                CMD_LIT:
                begin
                    final_out = head.last;
                    if (pend_valid_reg)
                    begin
                        two        = 1'b1;
                        first_byte = pend_byte_reg;
                        if (can_emit)
                        begin
                            emit            = 1'b1;
                            finish          = 1'b1;
                            pend_valid_next = 1'b0;
                        end
                    end
                    else if (head.last || at_edge)
                    begin
                        if (can_emit)
                        begin
                            emit   = 1'b1;
                            finish = 1'b1;
                        end
                    end
                    else
                    begin
                        pend_valid_next = 1'b1;
                        pend_byte_next  = head.value;
                        finish          = 1'b1;
                    end
                end
                CMD_RUN:
                begin
                    if (left_cur == '0)
                    begin
                        finish = 1'b1;
                    end
                    else if (can_emit)
                    begin
                        emit     = 1'b1;
                        two      = !(left_cur == 7'd1 || at_edge);
                        left_new = left_cur - (two ? 7'd2 : 7'd1);
                        if (left_new == '0)
                        begin
                            finish    = 1'b1;
                            final_out = 1'b1;
                        end
                        else
                        begin
                            run_left_next   = left_new;
                            run_active_next = 1'b1;
                        end
                    end
                end
            endcase
        end

        if (emit)
        begin
            col_next = col_reg + (two ? COL_W'(2) : COL_W'(1));
        end
        if (finish)
        begin
            run_active_next = 1'b0;
            if (head.done)
            begin
                col_next        = '0;
                pend_valid_next = 1'b0;
            end
        end
        pop = finish;

        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_channel_reg   <= head.channel;
            out_column_reg    <= 15'(col_reg);
            out_first_reg     <= first_byte;
            out_second_reg    <= two ? head.value : 8'd0;
            out_pair_reg      <= two;
            out_in_range_reg  <= (col_reg < eff_width);
            out_last_reg      <= final_out && head.last;
            out_row_end_reg   <= final_out && head.row_end;
            out_image_end_reg <= final_out && head.image_end;
        end
        pend_byte_reg <= pend_byte_next;
        run_left_reg  <= run_left_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg        <= '0;
            pend_valid_reg <= 1'b0;
            run_active_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            col_reg        <= col_next;
            pend_valid_reg <= pend_valid_next;
            run_active_reg <= run_active_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    assign results.valid          = out_valid_reg;
    assign results.channel        = out_channel_reg;
    assign results.column         = out_column_reg;
    assign results.first_value    = out_first_reg;
    assign results.second_value   = out_second_reg;
    assign results.pair_valid     = out_pair_reg;
    assign results.in_range       = out_in_range_reg;
    assign results.last_of_packet = out_last_reg;
    assign results.row_end        = out_row_end_reg;
    assign results.image_end      = out_image_end_reg;

endmodule

`default_nettype wire

/* design/rgbe_scanline_rle_decoder.sv */
// rgbe_scanline_rle_decoder: top level, configuration registers, front end,
// command queue and back end; depends on rsd_pkg and the three channel interfaces
//
// channel       role    width of payload   contents
// cfg           sink    2 + 15             reg_index, wdata (row_width, row_total)
// pixel_bytes   sink    8                  in_byte, one raw body byte
// results       source  2+15+8+8+1+1+1+1+1 channel, column, two bytes and marks
//
// header, count and literal bytes are taken one per cycle while the four-entry
// command queue has room; a run value byte occupies the back end until its run
// is expanded into results of two bytes, or of one byte for an odd last byte
// or the last byte inside the row width; empty packets emit no result
// the result register reloads in the cycle its transaction completes, so a taken
// result costs no bubble; a full queue holds off input, a waiting result holds
// the back end; reset clears all control state and sets both registers to 1
`default_nettype none

module rgbe_scanline_rle_decoder
    import rsd_pkg::*;
#(
    parameter int MAX_WIDTH = RSD_MAX_WIDTH
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    rgbe_cfg_if.sink        cfg,
    rgbe_byte_if.sink       pixel_bytes,
    rgbe_result_if.source   results
);

    localparam int COL_W = $clog2(MAX_WIDTH + 256);

    logic [14:0]        row_width_reg;
    logic [14:0]        row_total_reg;
    logic [14:0]        width_clamped;
    logic [COL_W-1:0]   eff_width;
    logic [14:0]        eff_total;

    rsd_q_status_t      q_status;
    rsd_cmd_t           push_data;
    rsd_cmd_t           head;
    logic               push;
    logic               pop;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width_reg <= 15'd1;
            row_total_reg <= 15'd1;
        end
        else if (cfg.valid && cfg.ready)
        begin
            if (cfg.reg_index == REG_ROW_WIDTH)
            begin
                row_width_reg <= cfg.wdata;
            end
            else if (cfg.reg_index == REG_ROW_TOTAL)
            begin
                row_total_reg <= cfg.wdata;
            end
        end
    end

    // zero width acts as one, large widths clamp to the maximum
    always_comb
    begin
        if (row_width_reg == '0)
        begin
            width_clamped = 15'd1;
        end
        else if (row_width_reg > 15'(MAX_WIDTH))
        begin
            width_clamped = 15'(MAX_WIDTH);
        end
        else
        begin
            width_clamped = row_width_reg;
        end
        eff_width = COL_W'(width_clamped);
        eff_total = (row_total_reg == '0) ? 15'd1 : row_total_reg;
    end

    rsd_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_bytes (pixel_bytes),
        .eff_width   (eff_width),
        .eff_total   (eff_total),
        .q_status    (q_status),
        .push        (push),
        .push_data   (push_data)
    );

    rsd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .status    (q_status)
    );

    rsd_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .eff_width (eff_width),
        .head      (head),
        .q_status  (q_status),
        .pop       (pop),
        .results   (results)
    );

    // a waiting result keeps its payload until taken
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && !results.ready
        |=> results.valid && $stable({results.channel, results.column,
                                      results.first_value, results.second_value,
                                      results.pair_valid, results.in_range,
                                      results.last_of_packet, results.row_end,
                                      results.image_end}))
        else $error("result changed or dropped while waiting");

    a_row_end_marks: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.row_end
        |-> results.last_of_packet && (results.channel == CH_EXPONENT))
        else $error("row end outside the exponent plane or not at a packet end");

    a_image_end_row: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.image_end |-> results.row_end)
        else $error("image end without row end");

endmodule

`default_nettype wire
